// ----- design/r2fft_pkg.sv -----
// ============================================================================
// r2fft_pkg
// Shared constants, controller/datapath types and twiddle generation for the
// framed radix-2 decimation-in-time FFT.
// ============================================================================
package r2fft_pkg;

  localparam int MAX_LOG2_POINTS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int CFG_W   = 4;
  localparam int BIN_W   = 10;
  localparam int OUT_W   = 26;
  localparam int TW_W    = 17;
  localparam int Q15_SH  = 15;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
  localparam logic             CMD_PUSH  = 1'b0;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam longint unsigned TAYLOR_COS_DIV [1:14] = '{
    64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };
  localparam longint unsigned TAYLOR_SIN_DIV [1:14] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  typedef struct packed {
    logic take;
    logic drain_rd;
    logic drain_out;
    logic xf_start;
    logic ld_rd;
    logic ld_wr;
    logic bf_ra;
    logic bf_rb;
    logic bf_m1;
    logic bf_m2;
    logic bf_add;
    logic bf_wa;
    logic bf_wb;
    logic xf_done;
  } dp_cmd_t;

  typedef struct packed {
    logic pending;
    logic frame_full;
    logic out_free;
    logic ld_last;
    logic bf_last;
  } dp_stat_t;

  function automatic longint q30_to_q15(input longint v);
    longint r;
    if (v < 0) begin
      r = 0;
    end else begin
      r = (v + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
    end
    return r;
  endfunction

  // Elaboration-time twiddle entry k: {cos, sin}, Q15, Taylor series in Q30
  function automatic logic [2*TW_W-1:0] tw_entry(input longint unsigned k,
                                                 input int unsigned maxlog);
    longint unsigned npts;
    longint unsigned ang;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint          sc;
    longint          ss;
    longint          cq;
    longint          sq;
    logic            first;
    npts  = 64'd1 << maxlog;
    first = ((4 * k) <= npts);
    ang   = first ? k : ((npts >> 1) - k);
    x     = (2 * PI_Q30 * ang) >> maxlog;
    x2    = (x * x) >> 30;
    tc    = 64'd1 << 30;
    ts    = x;
    sc    = longint'(tc);
    ss    = longint'(ts);
    for (int i = 1; i <= 14; i++) begin
      tc = ((tc * x2) >> 30) / TAYLOR_COS_DIV[i];
      ts = ((ts * x2) >> 30) / TAYLOR_SIN_DIV[i];
      if ((i % 2) == 1) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    cq = q30_to_q15(sc);
    sq = q30_to_q15(ss);
    if (!first) begin
      cq = -cq;
    end
    return {cq[TW_W-1:0], sq[TW_W-1:0]};
  endfunction

endpackage

// ----- design/r2fft_ram.sv -----
// ============================================================================
// r2fft_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module r2fft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/r2fft_ctrl.sv -----
// ============================================================================
// r2fft_ctrl
// Sequencer: item intake, bin drain, bit-reversed load and butterfly steps.
// ============================================================================
module r2fft_ctrl
  import r2fft_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_LD_RD = 4'd3;
  localparam logic [3:0] S_LD_WR = 4'd4;
  localparam logic [3:0] S_BF_RA = 4'd5;
  localparam logic [3:0] S_BF_RB = 4'd6;
  localparam logic [3:0] S_BF_M1 = 4'd7;
  localparam logic [3:0] S_BF_M2 = 4'd8;
  localparam logic [3:0] S_BF_AD = 4'd9;
  localparam logic [3:0] S_BF_WA = 4'd10;
  localparam logic [3:0] S_BF_WB = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.pending) begin
            cmd.drain_rd = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.drain_out = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.frame_full) begin
          cmd.xf_start = 1'b1;
          state_nxt    = S_LD_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LD_RD: begin
        cmd.ld_rd = 1'b1;
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = stat.ld_last ? S_BF_RA : S_LD_RD;
      end
      S_BF_RA: begin
        cmd.bf_ra = 1'b1;
        state_nxt = S_BF_RB;
      end
      S_BF_RB: begin
        cmd.bf_rb = 1'b1;
        state_nxt = S_BF_M1;
      end
      S_BF_M1: begin
        cmd.bf_m1 = 1'b1;
        state_nxt = S_BF_M2;
      end
      S_BF_M2: begin
        cmd.bf_m2 = 1'b1;
        state_nxt = S_BF_AD;
      end
      S_BF_AD: begin
        cmd.bf_add = 1'b1;
        state_nxt  = S_BF_WA;
      end
      S_BF_WA: begin
        cmd.bf_wa = 1'b1;
        state_nxt = S_BF_WB;
      end
      S_BF_WB: begin
        cmd.bf_wb = 1'b1;
        if (stat.bf_last) begin
          cmd.xf_done = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_BF_RA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/r2fft_dp.sv -----
// ============================================================================
// r2fft_dp
// Datapath: sample and bin stores, counters, twiddle ROM, butterfly
// arithmetic and the output register.
// ============================================================================
module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic        [CFG_W-1:0]       cfg_wdata,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [BIN_W-1:0]       out_bin_index,
  output logic signed [OUT_W-1:0]       out_real_part,
  output logic signed [OUT_W-1:0]       out_imag_part,
  output logic                          out_last_bin,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat
);

  localparam int L     = MAX_LOG2_POINTS;
  localparam int NPTS  = 1 << L;
  localparam int NW    = L + 1;
  localparam int SW    = $clog2(L + 1);
  localparam int DW    = SAMPLE_BITS + L + 2;
  localparam int PW    = DW + TW_W;
  localparam int XW    = ((DW > OUT_W) ? DW : OUT_W) + 1;
  localparam int TW_N  = 1 << (L - 1);
  localparam int TWA   = (L > 1) ? (L - 1) : 1;

  localparam logic signed [PW:0]    RND     = (PW + 1)'(1 << (Q15_SH - 1));
  localparam logic signed [XW-1:0]  SAT_MAX = XW'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [XW-1:0]  SAT_MIN = -XW'(64'sd1 <<< (OUT_W - 1));

  // twiddle ROM
  logic signed [TW_W-1:0] tw_cos_rom [TW_N];
  logic signed [TW_W-1:0] tw_sin_rom [TW_N];

  for (genvar g = 0; g < TW_N; g++) begin : g_tw
    localparam logic [2*TW_W-1:0] ENT = tw_entry(g, L);
    assign tw_cos_rom[g] = ENT[2*TW_W-1:TW_W];
    assign tw_sin_rom[g] = ENT[TW_W-1:0];
  end

  logic [CFG_W-1:0]  cfg_r;
  logic [SW-1:0]     eff_l;
  logic [NW-1:0]     n_pts;
  logic [L-1:0]      n_m1;
  logic [L-1:0]      nh_m1;

  logic [L-1:0]      fill_r;
  logic [L-1:0]      drain_r;
  logic              pending_r;
  logic              run_r;
  logic [L-1:0]      ld_i_r;
  logic [L-1:0]      bf_b_r;
  logic [SW-1:0]     stage_r;

  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic signed [OUT_W-1:0] out_re_r;
  logic signed [OUT_W-1:0] out_im_r;
  logic              out_last_r;

  logic signed [TW_W-1:0] tw_c_r;
  logic signed [TW_W-1:0] tw_s_r;
  logic [2*DW-1:0]   a_r;
  logic [2*DW-1:0]   b_r;
  logic signed [PW-1:0] pr0_r;
  logic signed [PW-1:0] pr1_r;
  logic signed [PW-1:0] pr2_r;
  logic signed [PW-1:0] pr3_r;
  logic signed [DW-1:0] t_re_r;
  logic signed [DW-1:0] t_im_r;

  logic [L-1:0]      rev_i;
  logic [L-1:0]      rev_full;
  logic [L-1:0]      hbit;
  logic [L-1:0]      hmask;
  logic [L-1:0]      k_lo;
  logic [L-1:0]      k_a;
  logic [L-1:0]      k_b;
  logic [L-1:0]      tw_full;
  logic [TWA-1:0]    tw_idx;

  logic                   smp_we;
  logic [SAMPLE_BITS-1:0] smp_rd;
  logic signed [SAMPLE_BITS-1:0] smp_s;

  logic              bin_we;
  logic [L-1:0]      bin_waddr;
  logic [2*DW-1:0]   bin_wdata;
  logic              bin_re_en;
  logic [L-1:0]      bin_raddr;
  logic [2*DW-1:0]   bin_rd;

  logic signed [DW-1:0] rd_re;
  logic signed [DW-1:0] rd_im;
  logic signed [DW-1:0] a_re;
  logic signed [DW-1:0] a_im;
  logic signed [DW-1:0] b_re;
  logic signed [DW-1:0] b_im;
  logic signed [PW:0]   sum_re;
  logic signed [PW:0]   sum_im;
  logic signed [PW:0]   sh_re;
  logic signed [PW:0]   sh_im;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DW-1:0] v);
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] r;
    vx = XW'(v);
    if (vx > SAT_MAX) begin
      r = SAT_MAX;
    end else if (vx < SAT_MIN) begin
      r = SAT_MIN;
    end else begin
      r = vx;
    end
    return r[OUT_W-1:0];
  endfunction

  always_comb begin
    if (cfg_r == '0) begin
      eff_l = SW'(1);
    end else if (int'(cfg_r) > L) begin
      eff_l = SW'(L);
    end else begin
      eff_l = SW'(cfg_r);
    end
  end

  assign n_pts = NW'(1) << eff_l;
  assign n_m1  = L'(n_pts - NW'(1));
  assign nh_m1 = L'((n_pts >> 1) - NW'(1));

  always_comb begin
    for (int i = 0; i < L; i++) begin
      rev_full[i] = ld_i_r[L-1-i];
    end
  end
  assign rev_i = rev_full >> (SW'(L) - eff_l);

  assign hbit    = L'(1) << (stage_r - SW'(1));
  assign hmask   = hbit - L'(1);
  assign k_lo    = bf_b_r & hmask;
  assign k_a     = ((bf_b_r & ~hmask) << 1) | k_lo;
  assign k_b     = k_a | hbit;
  assign tw_full = k_lo << (SW'(L) - stage_r);
  assign tw_idx  = tw_full[TWA-1:0];

  assign smp_we = cmd.take && (in_command == CMD_PUSH);
  assign smp_s  = smp_rd;

  r2fft_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NPTS)
  ) u_smp_ram (
    .clk     (clk),
    .wr_en   (smp_we),
    .wr_addr (fill_r),
    .wr_data (in_sample),
    .rd_en   (cmd.ld_rd),
    .rd_addr (rev_i),
    .rd_data (smp_rd)
  );

  assign rd_re = bin_rd[2*DW-1:DW];
  assign rd_im = bin_rd[DW-1:0];
  assign a_re  = a_r[2*DW-1:DW];
  assign a_im  = a_r[DW-1:0];
  assign b_re  = b_r[2*DW-1:DW];
  assign b_im  = b_r[DW-1:0];

  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = ld_i_r;
    bin_wdata = {DW'(smp_s), {DW{1'b0}}};
    if (cmd.ld_wr) begin
      bin_we = 1'b1;
    end else if (cmd.bf_wa) begin
      bin_we    = 1'b1;
      bin_waddr = k_a;
      bin_wdata = {a_re + t_re_r, a_im + t_im_r};
    end else if (cmd.bf_wb) begin
      bin_we    = 1'b1;
      bin_waddr = k_b;
      bin_wdata = {a_re - t_re_r, a_im - t_im_r};
    end
  end

  assign bin_re_en = cmd.drain_rd || cmd.bf_ra || cmd.bf_rb;

  always_comb begin
    if (cmd.bf_ra) begin
      bin_raddr = k_a;
    end else if (cmd.bf_rb) begin
      bin_raddr = k_b;
    end else begin
      bin_raddr = drain_r;
    end
  end

  r2fft_ram #(
    .WIDTH (2 * DW),
    .DEPTH (NPTS)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_we),
    .wr_addr (bin_waddr),
    .wr_data (bin_wdata),
    .rd_en   (bin_re_en),
    .rd_addr (bin_raddr),
    .rd_data (bin_rd)
  );

  assign sum_re = {pr0_r[PW-1], pr0_r} + {pr1_r[PW-1], pr1_r} + RND;
  assign sum_im = {pr2_r[PW-1], pr2_r} - {pr3_r[PW-1], pr3_r} + RND;
  assign sh_re  = sum_re >>> Q15_SH;
  assign sh_im  = sum_im >>> Q15_SH;

  always_ff @(posedge clk) begin
    if (cmd.bf_ra) begin
      tw_c_r <= tw_cos_rom[tw_idx];
      tw_s_r <= tw_sin_rom[tw_idx];
    end
    if (cmd.bf_rb) begin
      a_r <= bin_rd;
    end
    if (cmd.bf_m1) begin
      b_r   <= bin_rd;
      pr0_r <= tw_c_r * rd_re;
      pr1_r <= tw_s_r * rd_im;
    end
    if (cmd.bf_m2) begin
      pr2_r <= tw_c_r * b_im;
      pr3_r <= tw_s_r * b_re;
    end
    if (cmd.bf_add) begin
      t_re_r <= sh_re[DW-1:0];
      t_im_r <= sh_im[DW-1:0];
    end
    if (cmd.drain_out) begin
      out_bin_r  <= BIN_W'(drain_r);
      out_re_r   <= sat_out(rd_re);
      out_im_r   <= sat_out(rd_im);
      out_last_r <= (drain_r == n_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      fill_r      <= '0;
      drain_r     <= '0;
      pending_r   <= 1'b0;
      run_r       <= 1'b0;
      ld_i_r      <= '0;
      bf_b_r      <= '0;
      stage_r     <= SW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.drain_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (smp_we) begin
        if (fill_r == n_m1) begin
          fill_r <= '0;
          run_r  <= 1'b1;
        end else begin
          fill_r <= fill_r + L'(1);
        end
      end
      if (cmd.drain_out) begin
        if (drain_r == n_m1) begin
          drain_r   <= '0;
          pending_r <= 1'b0;
        end else begin
          drain_r <= drain_r + L'(1);
        end
      end
      if (cmd.xf_start) begin
        run_r   <= 1'b0;
        ld_i_r  <= '0;
        bf_b_r  <= '0;
        stage_r <= SW'(1);
      end
      if (cmd.ld_wr) begin
        ld_i_r <= ld_i_r + L'(1);
      end
      if (cmd.bf_wb) begin
        if (bf_b_r == nh_m1) begin
          bf_b_r  <= '0;
          stage_r <= stage_r + SW'(1);
        end else begin
          bf_b_r <= bf_b_r + L'(1);
        end
      end
      if (cmd.xf_done) begin
        pending_r <= 1'b1;
        drain_r   <= '0;
      end
      if (cfg_we) begin
        cfg_r     <= cfg_wdata;
        fill_r    <= '0;
        drain_r   <= '0;
        pending_r <= 1'b0;
        run_r     <= 1'b0;
      end
    end
  end

  assign stat.pending    = pending_r;
  assign stat.frame_full = run_r;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.ld_last    = (ld_i_r == n_m1);
  assign stat.bf_last    = (bf_b_r == nh_m1) && (stage_r == eff_l);

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_r;
  assign out_real_part = out_re_r;
  assign out_imag_part = out_im_r;
  assign out_last_bin  = out_last_r;

endmodule

// ----- design/radix2_fft_real_frame_top.sv -----
// ============================================================================
// radix2_fft_real_frame_top
// Framed real-input radix-2 DIT FFT: collects samples, transforms a full
// frame in place with one butterfly unit and drains one bin per item.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_wdata (log2_points)
//   in       in         in_valid/in_ready    in_command, in_sample
//   out      out        out_valid/out_ready  out_bin_index, out_real_part,
//                                            out_imag_part, out_last_bin
//
// An item without a result passes the intake and frame-check states; one
// with a result also reads a bin and waits in the emit state for the output
// register. The item that completes a frame of N points adds a bit-reversed
// load and N/2*log2(N) butterflies of read A, read B, two multiplies, add,
// write A and write B. rst_n is synchronous; reset clears control state
// only. in_ready is low outside idle, as in drain waits and the transform.
// ============================================================================
module radix2_fft_real_frame_top
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic        [CFG_W-1:0]       cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [BIN_W-1:0]       out_bin_index,
  output logic signed [OUT_W-1:0]       out_real_part,
  output logic signed [OUT_W-1:0]       out_imag_part,
  output logic                          out_last_bin
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  r2fft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  r2fft_dp #(
    .MAX_LOG2_POINTS (MAX_LOG2_POINTS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_command    (in_command),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_real_part (out_real_part),
    .out_imag_part (out_imag_part),
    .out_last_bin  (out_last_bin),
    .cmd           (cmd),
    .stat          (stat)
  );

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !stat.pending)
    else $error("config write did not drop pending bins");

  a_bin_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_wr, cmd.bf_wa, cmd.bf_wb}))
    else $error("bin store write conflict");

  a_bin_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.drain_rd, cmd.bf_ra, cmd.bf_rb}))
    else $error("bin store read conflict");

  a_wa_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bf_wa |=> cmd.bf_wb && !in_ready)
    else $error("butterfly write pair broken");

endmodule
